[sv/cmafi_pkg.sv]
// ---------------------------------------------------------------------------
// cmafi_pkg: shared constants for the mode amplitude fix and invert block
// Pipeline depths of the square root and divider units and the register
// index codes of the configuration port.
// ---------------------------------------------------------------------------
package cmafi_pkg;

	// Square root: 32 root bits, two per stage.
	localparam int unsigned ROOT_BITS  = 32;
	localparam int unsigned SQ_STEPS   = 2;
	localparam int unsigned SQ_STAGES  = ROOT_BITS / SQ_STEPS;

	// Divider: 32 quotient bits, four per stage.
	localparam int unsigned QUOT_BITS  = 32;
	localparam int unsigned DIV_STEPS  = 4;
	localparam int unsigned DIV_STAGES = QUOT_BITS / DIV_STEPS;

	typedef enum logic [1:0] {
		REG_FIX_ENABLE    = 2'd0,
		REG_INVERT_ENABLE = 2'd1,
		REG_TARGET_AMPL   = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_index_t;

	localparam logic [31:0] TARGET_AMPL_RESET = 32'h0100_0000;

endpackage

[sv/cmafi_sqrt.sv]
// ---------------------------------------------------------------------------
// cmafi_sqrt: pipelined integer square root
// Floor square root of a 64-bit radicand, two result bits per stage.
// ---------------------------------------------------------------------------
module cmafi_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a, input int unsigned k);
		logic [63:0] b;
		logic [63:0] t;
		sq_t         o;
		b = 64'd1 << (2 * k);
		t = a.r + b;
		if (a.v >= t) begin
			o.v = a.v - t;
			o.r = (a.r >> 1) + b;
		end else begin
			o.v = a.v;
			o.r = a.r >> 1;
		end
		return o;
	endfunction

	sq_t stg_s [cmafi_pkg::SQ_STAGES];

	for (genvar s = 0; s < cmafi_pkg::SQ_STAGES; s++) begin : g_stage
		sq_t nxt;
		always_comb begin
			sq_t t;
			if (s == 0) begin
				t.v = rad;
				t.r = '0;
			end else begin
				t = stg_s[(s == 0) ? 0 : s - 1];
			end
			for (int j = 0; j < int'(cmafi_pkg::SQ_STEPS); j++) begin
				t = sq_step(t, cmafi_pkg::ROOT_BITS - 1 - (s * cmafi_pkg::SQ_STEPS + j));
			end
			nxt = t;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[s] <= nxt;
			end
		end
	end

	assign root = stg_s[cmafi_pkg::SQ_STAGES-1].r[31:0];

endmodule

[sv/cmafi_div.sv]
// ---------------------------------------------------------------------------
// cmafi_div: pipelined restoring divider
// Divides a 64-bit dividend by a 32-bit divisor whose quotient fits in
// 32 bits, four quotient bits per stage.
// ---------------------------------------------------------------------------
module cmafi_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quot
);

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] low;
		logic [31:0] q;
		logic [31:0] d;
	} dv_t;

	function automatic dv_t dv_step(input dv_t a);
		logic [32:0] r33;
		dv_t         o;
		r33   = {a.rem, a.low[31]};
		o.low = a.low << 1;
		o.d   = a.d;
		if (r33 >= {1'b0, a.d}) begin
			o.rem = 32'(r33 - {1'b0, a.d});
			o.q   = {a.q[30:0], 1'b1};
		end else begin
			o.rem = r33[31:0];
			o.q   = {a.q[30:0], 1'b0};
		end
		return o;
	endfunction

	dv_t stg_s [cmafi_pkg::DIV_STAGES];

	for (genvar s = 0; s < cmafi_pkg::DIV_STAGES; s++) begin : g_stage
		dv_t nxt;
		always_comb begin
			dv_t t;
			if (s == 0) begin
				// The high half is below the divisor because the quotient fits.
				t.rem = dividend[63:32];
				t.low = dividend[31:0];
				t.q   = '0;
				t.d   = divisor;
			end else begin
				t = stg_s[(s == 0) ? 0 : s - 1];
			end
			for (int j = 0; j < int'(cmafi_pkg::DIV_STEPS); j++) begin
				t = dv_step(t);
			end
			nxt = t;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[s] <= nxt;
			end
		end
	end

	assign quot = stg_s[cmafi_pkg::DIV_STAGES-1].q;

endmodule

[sv/complex_mode_amplitude_fix_invert_core.sv]
// ---------------------------------------------------------------------------
// complex_mode_amplitude_fix_invert_core: mode amplitude fix and invert
// Rescales a nonzero complex mode to the target amplitude keeping its
// phase, optionally negates it, and saturates both parts.
//
//   channel  signals                                   direction
//   input    in_valid, in_ready, mode_real, mode_imag  into the block
//   output   out_valid, out_ready, out_real, out_imag  out of the block
//   config   write_enable, reg_index, write_data       into the block
//
// One beat is accepted every cycle while the output is not stalled; the pipeline depth
// is set by the two-bit-per-stage square root and four-bit-per-stage dividers.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline; in_ready drops only
// while the last stage holds a beat that is not taken.
// ---------------------------------------------------------------------------
module complex_mode_amplitude_fix_invert_core #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] mode_real,
	input  logic [31:0] mode_imag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_real,
	output logic [31:0] out_imag,
	input  logic        write_enable,
	input  logic [1:0]  reg_index,
	input  logic [31:0] write_data
);

	localparam int unsigned EFF = (SAMPLE_WIDTH > 32) ? 32 : SAMPLE_WIDTH;
	localparam logic [32:0] MASK33 = (33'd1 << EFF) - 33'd1;
	localparam logic [31:0] MASK = MASK33[31:0];
	localparam logic [32:0] HALF = 33'd1 << (EFF - 1);
	localparam int unsigned NSQ = cmafi_pkg::SQ_STAGES;
	localparam int unsigned NDV = cmafi_pkg::DIV_STAGES;
	localparam int unsigned NTOT = 3 + NSQ + 2 + NDV + 1;

	typedef struct packed {
		logic        nr;
		logic        ni;
		logic        zero;
		logic [31:0] mr;
		logic [31:0] mi;
	} side_t;

	function automatic logic [31:0] sat(input logic neg, input logic [31:0] mag);
		logic [32:0] m;
		m = {1'b0, mag};
		if (neg) begin
			if (m > HALF) m = HALF;
			m = 33'd0 - m;
		end else begin
			if (m > HALF - 33'd1) m = HALF - 33'd1;
		end
		return m[31:0];
	endfunction

	// Configuration registers.
	logic        fix_enable_q;
	logic        invert_enable_q;
	logic [31:0] target_amplitude_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_enable_q       <= 1'b0;
			invert_enable_q    <= 1'b0;
			target_amplitude_q <= cmafi_pkg::TARGET_AMPL_RESET;
		end else if (write_enable) begin
			unique case (cmafi_pkg::reg_index_t'(reg_index))
				cmafi_pkg::REG_FIX_ENABLE:    fix_enable_q <= write_data[0];
				cmafi_pkg::REG_INVERT_ENABLE: invert_enable_q <= write_data[0];
				cmafi_pkg::REG_TARGET_AMPL:   target_amplitude_q <= write_data;
				default: ;
			endcase
		end
	end

	// Valid bits and global advance.
	logic [NTOT-1:0] vld_s;
	logic            adv;

	assign adv       = !vld_s[NTOT-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[NTOT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NTOT-2:0], in_valid};
		end
	end

	// Stage 1: sign and magnitude within the sample width.
	logic [31:0] xr, xi, mag_r, mag_i;
	side_t       side_s1;

	always_comb begin
		xr    = mode_real & MASK;
		xi    = mode_imag & MASK;
		mag_r = xr[EFF-1] ? ((~xr + 32'd1) & MASK) : xr;
		mag_i = xi[EFF-1] ? ((~xi + 32'd1) & MASK) : xi;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.nr   <= xr[EFF-1];
			side_s1.ni   <= xi[EFF-1];
			side_s1.zero <= (mag_r == 32'd0) && (mag_i == 32'd0);
			side_s1.mr   <= mag_r;
			side_s1.mi   <= mag_i;
		end
	end

	// Stages 2 and 3: squares, then their sum.
	logic [63:0] sqr_s2, sqi_s2, sum_s3;
	side_t       side_s2, side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqr_s2  <= 64'(side_s1.mr) * 64'(side_s1.mr);
			sqi_s2  <= 64'(side_s1.mi) * 64'(side_s1.mi);
			side_s2 <= side_s1;
			sum_s3  <= sqr_s2 + sqi_s2;
			side_s3 <= side_s2;
		end
	end

	// Norm of the mode.
	logic [31:0] norm;
	side_t       sqd_s [NSQ];

	cmafi_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (sum_s3),
		.root (norm)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sqd_s[0] <= side_s3;
			for (int i = 1; i < int'(NSQ); i++) begin
				sqd_s[i] <= sqd_s[i-1];
			end
		end
	end

	// Stage 4: scale by the target amplitude; stage 5: add the rounding term.
	logic [63:0] prod_r_s4, prod_i_s4, dvd_r_s5, dvd_i_s5;
	logic [31:0] n_s4, n_s5;
	side_t       side_s4, side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_r_s4 <= 64'(sqd_s[NSQ-1].mr) * 64'(target_amplitude_q);
			prod_i_s4 <= 64'(sqd_s[NSQ-1].mi) * 64'(target_amplitude_q);
			n_s4      <= norm;
			side_s4   <= sqd_s[NSQ-1];
			dvd_r_s5  <= prod_r_s4 + 64'(n_s4 >> 1);
			dvd_i_s5  <= prod_i_s4 + 64'(n_s4 >> 1);
			n_s5      <= n_s4;
			side_s5   <= side_s4;
		end
	end

	// Rounded quotients; the magnitude never exceeds the norm, so they fit.
	logic [31:0] quot_r, quot_i;
	side_t       dvs_s [NDV];

	cmafi_div u_div_real (
		.clk      (clk),
		.en       (adv),
		.dividend (dvd_r_s5),
		.divisor  (n_s5),
		.quot     (quot_r)
	);

	cmafi_div u_div_imag (
		.clk      (clk),
		.en       (adv),
		.dividend (dvd_i_s5),
		.divisor  (n_s5),
		.quot     (quot_i)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			dvs_s[0] <= side_s5;
			for (int i = 1; i < int'(NDV); i++) begin
				dvs_s[i] <= dvs_s[i-1];
			end
		end
	end

	// Final stage: select, invert and saturate.
	side_t       fin;
	logic [31:0] res_real_s6, res_imag_s6;

	assign fin = dvs_s[NDV-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin.zero) begin
				res_real_s6 <= '0;
				res_imag_s6 <= '0;
			end else begin
				res_real_s6 <= sat(fin.nr ^ invert_enable_q, fix_enable_q ? quot_r : fin.mr);
				res_imag_s6 <= sat(fin.ni ^ invert_enable_q, fix_enable_q ? quot_i : fin.mi);
			end
		end
	end

	assign out_real = res_real_s6;
	assign out_imag = res_imag_s6;

endmodule

[dv/complex_mode_amplitude_fix_invert_core_tb.sv]
// ---------------------------------------------------------------------------
// Testbench for complex_mode_amplitude_fix_invert_core
// Drives complex modes with bursty valid and a stalling receiver, predicts
// each result with an exact fixed-point model of the amplitude fix and
// inversion, and compares every output beat in order.
// ---------------------------------------------------------------------------
module complex_mode_amplitude_fix_invert_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
	} mode_t;

	class mode_scoreboard;
		mode_t pending[$];
		bit fix_on;
		bit invert_on;
		logic [31:0] amplitude;
		int mismatches;
		int checked;

		function new();
			fix_on = 0;
			invert_on = 0;
			amplitude = cmafi_pkg::TARGET_AMPL_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function logic [31:0] saturate(bit neg, logic [63:0] mag);
			if (neg) begin
				if (mag > 64'h8000_0000) mag = 64'h8000_0000;
				return 32'(64'd0 - mag);
			end
			if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
			return mag[31:0];
		endfunction

		function void note_mode(mode_t m);
			mode_t e;
			bit nr, ni;
			logic [63:0] mr, mi, nrm;
			nr = m.re[31];
			ni = m.im[31];
			mr = nr ? {32'd0, -m.re} : {32'd0, m.re};
			mi = ni ? {32'd0, -m.im} : {32'd0, m.im};
			// The two's complement of -2^31 wraps to itself; its magnitude is 2^31.
			if (nr && mr == 0) mr = 64'h8000_0000;
			if (ni && mi == 0) mi = 64'h8000_0000;
			if (mr == 0 && mi == 0) begin
				e = '0;
			end else begin
				if (fix_on) begin
					nrm = int_sqrt(mr * mr + mi * mi);
					mr = (mr * amplitude + (nrm >> 1)) / nrm;
					mi = (mi * amplitude + (nrm >> 1)) / nrm;
				end
				if (invert_on) begin
					nr = !nr;
					ni = !ni;
				end
				e.re = saturate(nr, mr);
				e.im = saturate(ni, mi);
			end
			pending.push_back(e);
		endfunction

		function void check_mode(logic [31:0] re, logic [31:0] im);
			mode_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat re=%h im=%h", re, im);
				return;
			end
			e = pending.pop_front();
			if (re !== e.re || im !== e.im) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected re=%h im=%h, got re=%h im=%h",
						e.re, e.im, re, im);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [31:0] mode_real;
	logic [31:0] mode_imag;
	logic out_valid;
	logic out_ready;
	logic [31:0] out_real;
	logic [31:0] out_imag;
	logic write_enable;
	logic [1:0] reg_index;
	logic [31:0] write_data;

	mode_scoreboard modes;
	int sent;

	complex_mode_amplitude_fix_invert_core DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver stalls in runs, with long stretches of steady readiness.
	initial begin
		int run;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 40);
			repeat (run) begin
				@(posedge clk);
				out_ready <= ($urandom_range(0, 3) != 0) || (run > 30);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			modes.check_mode(out_real, out_imag);
	end

	task automatic write_reg(cmafi_pkg::reg_index_t idx, logic [31:0] data);
		@(posedge clk);
		write_enable <= 1;
		reg_index <= idx;
		write_data <= data;
		@(posedge clk);
		write_enable <= 0;
		case (idx)
			cmafi_pkg::REG_FIX_ENABLE: modes.fix_on = data[0];
			cmafi_pkg::REG_INVERT_ENABLE: modes.invert_on = data[0];
			cmafi_pkg::REG_TARGET_AMPL: modes.amplitude = data;
			default: ;
		endcase
	endtask

	task automatic send_mode(logic [31:0] re, logic [31:0] im);
		in_valid <= 1;
		mode_real <= re;
		mode_imag <= im;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		modes.note_mode('{re: re, im: im});
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (modes.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(int'($urandom_range(0, 64)) - 32);
			3: return 32'($signed($urandom) >>> $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int count);
		int gap;
		int k;
		k = 0;
		while (k < count) begin
			repeat ($urandom_range(1, 12)) begin
				if (k < count) begin
					send_mode(rand_field(), rand_field());
					k++;
				end
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		logic [31:0] ext[4];
		modes = new();
		sent = 0;
		arst_n = 0;
		in_valid = 0;
		mode_real = 0;
		mode_imag = 0;
		write_enable = 0;
		reg_index = cmafi_pkg::REG_FIX_ENABLE;
		write_data = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// Directed: zero mode, extremes, negation of the most negative value.
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001};
		for (int cfg = 0; cfg < 4; cfg++) begin
			write_reg(cmafi_pkg::REG_FIX_ENABLE, 32'(cfg[0]) | 32'hFFFF_FFFE);
			write_reg(cmafi_pkg::REG_INVERT_ENABLE, 32'(cfg[1]));
			write_reg(cmafi_pkg::REG_TARGET_AMPL,
				cfg == 3 ? 32'hFFFF_FFFF : cmafi_pkg::TARGET_AMPL_RESET);
			send_mode(ext[0], ext[0]);
			send_mode(ext[1], ext[2]);
			send_mode(ext[2], ext[2]);
			send_mode(ext[3], ext[0]);
			send_mode(32'hFFFF_FFFF, ext[1]);
			send_mode(32'h0100_0000, 32'hFF00_0000);
			drain();
		end
		write_reg(cmafi_pkg::REG_UNUSED, 32'h0);

		// Random: several register settings including the extreme amplitudes.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(cmafi_pkg::REG_FIX_ENABLE, $urandom);
			write_reg(cmafi_pkg::REG_INVERT_ENABLE, $urandom);
			case (ph)
				0: write_reg(cmafi_pkg::REG_TARGET_AMPL, 32'h0);
				1: write_reg(cmafi_pkg::REG_TARGET_AMPL, 32'hFFFF_FFFF);
				default: write_reg(cmafi_pkg::REG_TARGET_AMPL,
					$urandom >> $urandom_range(0, 16));
			endcase
			if (ph < 2) write_reg(cmafi_pkg::REG_FIX_ENABLE, 32'h1);
			random_phase(80);
			drain();
		end

		$display("Sent %0d modes across fix/invert settings and amplitudes 0 to max;", sent);
		$display("checked %0d output beats.", modes.checked);
		if (modes.mismatches == 0 && modes.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[complex_mode_amplitude_fix_invert_core.f]
sv/cmafi_pkg.sv
sv/cmafi_sqrt.sv
sv/cmafi_div.sv
sv/complex_mode_amplitude_fix_invert_core.sv
dv/complex_mode_amplitude_fix_invert_core_tb.sv
